// File: design/cbic_pkg.sv
package cbic_pkg;

  // Operation codes of an input transaction
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALT_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_LAST  = 1'b1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [7:0]  PRG_LAST_RESET = 8'h0F;

  // Address decoding
  localparam logic [15:0] ALT_OFFSET   = 16'h2000;
  localparam logic [15:0] ADDR_MASK    = 16'hE00F;
  localparam logic [11:0] REG_PAGE     = 12'h600;
  localparam logic [2:0]  WIN_NORMAL   = 3'b011;   // 0x6000-0x7FFF
  localparam logic [3:0]  REG_PRG      = 4'h8;
  localparam logic [3:0]  REG_MIRROR   = 4'h9;
  localparam logic [3:0]  REG_IRQ_CTRL = 4'hA;
  localparam logic [3:0]  REG_CNT_LO   = 4'hB;
  localparam logic [3:0]  REG_CNT_HI   = 4'hC;
  localparam logic [3:0]  PRG_MASK     = 4'hF;

  localparam logic [15:0] IRQ_FIRE_COUNT = 16'hFFFE;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_CHR      = 3'd1,
    KIND_PRG      = 3'd2,
    KIND_MIRROR   = 3'd3,
    KIND_IRQ_CTRL = 3'd4,
    KIND_CNT_BYTE = 3'd5
  } update_kind_e;

  // Decoded form of one input transaction
  typedef struct packed {
    logic         tick;
    update_kind_e kind;
    logic [2:0]   slot;
    logic [7:0]   data;
    logic         hi_byte;
  } dec_t;

  // One result transaction
  typedef struct packed {
    update_kind_e kind;
    logic [2:0]   slot;
    logic [7:0]   bank;
    logic [1:0]   mirror;
    logic [7:0]   fixed;
    logic         irq;
  } res_t;

endpackage

// File: design/cbic_if.sv
interface cbic_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] cpu_address;
  logic [7:0]  write_data;

  modport source (output valid, output op, output cpu_address, output write_data,
                  input ready);
  modport sink   (input valid, input op, input cpu_address, input write_data,
                  output ready);
endinterface

interface cbic_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] update_kind;
  logic [2:0] chr_slot;
  logic [7:0] bank_number;
  logic [1:0] mirror_mode;
  logic [7:0] fixed_bank;
  logic       irq_line;

  modport source (output valid, output update_kind, output chr_slot, output bank_number,
                  output mirror_mode, output fixed_bank, output irq_line,
                  input ready);
  modport sink   (input valid, input update_kind, input chr_slot, input bank_number,
                  input mirror_mode, input fixed_bank, input irq_line,
                  output ready);
endinterface

interface cbic_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cbic_pkg::CFG_IDX_W-1:0]  index;
  logic [cbic_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/cartridge_bank_and_irq_counter_core.sv
// Channel  | Dir | Payload                                              | Handshake
// in_i     | in  | op, cpu_address, write_data                          | valid/ready
// out_o    | out | update_kind, chr_slot, bank_number, mirror_mode,     | valid/ready
//          |     | fixed_bank, irq_line                                 |
// cfg_i    | in  | index (0 alt_mode, 1 prg_last_bank), data            | valid/ready
//
// One transaction per clock sustained while out_o.ready is high; each passes through
// the input register, then decode and state update into the result register.
// Reset clears control and counter state (not the input data or result registers),
// prg_last_bank resets to 15; no clearing pass. Output stall backs up into the input
// register; in_i.ready drops only when both are full. cfg_i.ready is always high.
module cartridge_bank_and_irq_counter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  cbic_in_if.sink     in_i,
  cbic_out_if.source  out_o,
  cbic_cfg_if.sink    cfg_i
);

  logic        alt_mode_q;
  logic [7:0]  prg_last_q;

  logic        s1_valid_q;
  logic        s1_op_q;
  logic [15:0] s1_addr_q;
  logic [7:0]  s1_data_q;
  logic        s2_valid_q;
  logic        s1_adv;
  logic        in_take;

  cbic_pkg::dec_t dec;
  cbic_pkg::res_t res;

  assign s1_adv  = s1_valid_q && (!s2_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_take = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alt_mode_q <= 1'b0;
      prg_last_q <= cbic_pkg::PRG_LAST_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        cbic_pkg::CFG_ALT_MODE: alt_mode_q <= cfg_i.data[0];
        cbic_pkg::CFG_PRG_LAST: prg_last_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_op_q   <= in_i.op;
      s1_addr_q <= in_i.cpu_address;
      s1_data_q <= in_i.write_data;
    end
  end

  cbic_decode u_decode (
    .op_i          (s1_op_q),
    .cpu_address_i (s1_addr_q),
    .write_data_i  (s1_data_q),
    .alt_mode_i    (alt_mode_q),
    .dec_o         (dec)
  );

  cbic_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (s1_adv),
    .dec_i      (dec),
    .alt_mode_i (alt_mode_q),
    .prg_last_i (prg_last_q),
    .res_o      (res)
  );

  assign out_o.valid       = s2_valid_q;
  assign out_o.update_kind = res.kind;
  assign out_o.chr_slot    = res.slot;
  assign out_o.bank_number = res.bank;
  assign out_o.mirror_mode = res.mirror;
  assign out_o.fixed_bank  = res.fixed;
  assign out_o.irq_line    = res.irq;

endmodule

// File: design/cbic_decode.sv
module cbic_decode (
  input  logic           op_i,
  input  logic [15:0]    cpu_address_i,
  input  logic [7:0]     write_data_i,
  input  logic           alt_mode_i,
  output cbic_pkg::dec_t dec_o
);

  logic        in_win;
  logic [15:0] addr_adj;
  logic [15:0] addr_m;

  assign in_win   = alt_mode_i ? cpu_address_i[15]
                               : (cpu_address_i[15:13] == cbic_pkg::WIN_NORMAL);
  assign addr_adj = alt_mode_i ? (cpu_address_i - cbic_pkg::ALT_OFFSET) : cpu_address_i;
  assign addr_m   = addr_adj & cbic_pkg::ADDR_MASK;

  always_comb begin
    dec_o.tick    = (op_i == cbic_pkg::OP_TICK);
    dec_o.kind    = cbic_pkg::KIND_NONE;
    dec_o.slot    = 3'd0;
    dec_o.data    = write_data_i;
    dec_o.hi_byte = (addr_m[3:0] == cbic_pkg::REG_CNT_HI);
    if (!dec_o.tick && in_win && addr_m[15:4] == cbic_pkg::REG_PAGE) begin
      if (!addr_m[3]) begin
        dec_o.kind = cbic_pkg::KIND_CHR;
        dec_o.slot = addr_m[2:0];
      end else begin
        case (addr_m[3:0])
          cbic_pkg::REG_PRG:      dec_o.kind = cbic_pkg::KIND_PRG;
          cbic_pkg::REG_MIRROR:   dec_o.kind = cbic_pkg::KIND_MIRROR;
          cbic_pkg::REG_IRQ_CTRL: dec_o.kind = cbic_pkg::KIND_IRQ_CTRL;
          cbic_pkg::REG_CNT_LO,
          cbic_pkg::REG_CNT_HI:   dec_o.kind = cbic_pkg::KIND_CNT_BYTE;
          default:                dec_o.kind = cbic_pkg::KIND_NONE;
        endcase
      end
    end
  end

endmodule

// File: design/cbic_regs.sv
module cbic_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  cbic_pkg::dec_t dec_i,
  input  logic           alt_mode_i,
  input  logic [7:0]     prg_last_i,
  output cbic_pkg::res_t res_o
);

  logic [1:0]  mirror_q, mirror_d;
  logic        irq_en_q, irq_en_d;
  logic        pend_q, pend_d;
  logic [15:0] count_q, count_d;
  logic [15:0] latch_q, latch_d;
  logic [15:0] byte_src;
  logic [15:0] byte_upd;
  cbic_pkg::res_t res_q, res_d;

  // Byte writes go to the latch in alternate mode, else to the counter
  assign byte_src = alt_mode_i ? latch_q : count_q;
  assign byte_upd = dec_i.hi_byte ? {dec_i.data, byte_src[7:0]}
                                  : {byte_src[15:8], dec_i.data};

  always_comb begin
    mirror_d = mirror_q;
    irq_en_d = irq_en_q;
    pend_d   = pend_q;
    count_d  = count_q;
    latch_d  = latch_q;
    if (dec_i.tick) begin
      if (irq_en_q) begin
        if (count_q == cbic_pkg::IRQ_FIRE_COUNT) begin
          pend_d   = 1'b1;
          irq_en_d = 1'b0;
        end else begin
          count_d = count_q - 16'd1;
        end
      end
    end else begin
      case (dec_i.kind)
        cbic_pkg::KIND_MIRROR: mirror_d = dec_i.data[1:0];
        cbic_pkg::KIND_IRQ_CTRL: begin
          irq_en_d = dec_i.data[0];
          pend_d   = 1'b0;
          if (alt_mode_i) begin
            count_d = latch_q;
          end
        end
        cbic_pkg::KIND_CNT_BYTE: begin
          if (alt_mode_i) begin
            latch_d = byte_upd;
          end else begin
            count_d = byte_upd;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_d.kind   = dec_i.kind;
    res_d.slot   = dec_i.slot;
    res_d.bank   = 8'd0;
    res_d.mirror = mirror_d;
    res_d.fixed  = prg_last_i;
    res_d.irq    = pend_d;
    case (dec_i.kind)
      cbic_pkg::KIND_CHR: res_d.bank = dec_i.data;
      cbic_pkg::KIND_PRG: res_d.bank = {4'd0, dec_i.data[3:0] & cbic_pkg::PRG_MASK};
      default:            res_d.bank = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_q <= 2'd0;
      irq_en_q <= 1'b0;
      pend_q   <= 1'b0;
      count_q  <= 16'd0;
      latch_q  <= 16'd0;
    end else if (step_i) begin
      mirror_q <= mirror_d;
      irq_en_q <= irq_en_d;
      pend_q   <= pend_d;
      count_q  <= count_d;
      latch_q  <= latch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

`ifndef SYNTHESIS
  // The IRQ line only rises from a tick that found the counter enabled
  a_irq_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pend_q) |-> $past(irq_en_q) && !irq_en_q)
    else $error("irq raised without enable");

  // Counter and latch move only when a transaction is applied
  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(count_q) && $stable(latch_q))
    else $error("irq counter changed without a transaction");

  // A result with no update carries no slot and no bank
  a_none_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && dec_i.kind == cbic_pkg::KIND_NONE |=> res_q.slot == 3'd0 && res_q.bank == 8'd0)
    else $error("idle result carries bank data");

  // A tick never produces an update kind
  a_tick_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && dec_i.tick |=> res_q.kind == cbic_pkg::KIND_NONE)
    else $error("tick produced an update");
`endif

endmodule
